/* hw/rtl/ist_pkg.sv */
// Shared types and constants for the INI stream tokeniser.
// Used by ist_ctrl, ist_datapath and ini_stream_tokenizer; depends on nothing.
package ist_pkg;

   localparam int PENDING_DEPTH = 16;
   localparam int LINE_BITS     = 20;
   localparam int COLUMN_BITS   = 16;
   localparam int HELD_BITS     = $clog2(PENDING_DEPTH + 1);
   localparam int ADDR_BITS     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [2:0] {
      K_SECTION_CHAR = 3'd0,
      K_NAME_CHAR    = 3'd1,
      K_VALUE_CHAR   = 3'd2,
      K_SECTION_DONE = 3'd3,
      K_NAME_DONE    = 3'd4,
      K_VALUE_DONE   = 3'd5,
      K_END          = 3'd6,
      K_ERROR        = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      E_NONE     = 3'd0,
      E_SYMBOL   = 3'd1,
      E_EARLY    = 3'd2,
      E_COMMENT  = 3'd3,
      E_LINE     = 3'd4,
      E_EMPTY    = 3'd5,
      E_OVERFLOW = 3'd6
   } err_type;

   // Source of the word loaded into the output register
   typedef enum logic [2:0] {
      OSEL_NONE,
      OSEL_DIRECT,
      OSEL_DRAIN,
      OSEL_HELD,
      OSEL_END
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      out_sel_type out_sel;
      logic        out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic step_has_res;
      logic step_drain;
      logic step_end2;
      logic held_end2;
      logic drain_last;
   } dp_status_type;

endpackage

/* hw/rtl/ist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ist_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ist_ctrl.sv */
// Sequencer for the tokeniser: input handshake, output valid, word ordering.
// Depends on ist_pkg.
module ist_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ist_pkg::dp_status_type status,
   output ist_pkg::ctl_cmd_type   cmd
);
   import ist_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DRAIN,
      S_FINAL,
      S_END2
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.out_sel  = OSEL_NONE;
      cmd.out_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && out_free) begin
               cmd.accept = 1'b1;
               if (status.step_drain) begin
                  state_in = S_DRAIN;
               end else if (status.step_has_res) begin
                  cmd.out_sel  = OSEL_DIRECT;
                  cmd.out_last = !status.step_end2;
                  if (status.step_end2) begin
                     state_in = S_END2;
                  end
               end
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               cmd.out_sel = OSEL_DRAIN;
               if (status.drain_last) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               cmd.out_sel  = OSEL_HELD;
               cmd.out_last = !status.held_end2;
               state_in     = status.held_end2 ? S_END2 : S_IDLE;
            end
         end
         S_END2: begin
            if (out_free) begin
               cmd.out_sel  = OSEL_END;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_sel != OSEL_NONE) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/ist_datapath.sv */
// Tokeniser datapath: parse state, position counters, held blank buffer, output word.
// Depends on ist_pkg and ist_ram.
module ist_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_at_end,
   input  ist_pkg::ctl_cmd_type              cmd,
   output ist_pkg::dp_status_type            status,
   output logic [2:0]                        rsp_kind,
   output logic [7:0]                        rsp_out_byte,
   output logic [2:0]                        rsp_error_code,
   output logic [ist_pkg::LINE_BITS-1:0]     rsp_line_number,
   output logic [ist_pkg::COLUMN_BITS-1:0]   rsp_column_number,
   output logic                              rsp_last_of_run
);
   import ist_pkg::*;

   typedef enum logic [2:0] {
      M_GEN,
      M_COMMENT,
      M_SECTION,
      M_PARAM,
      M_VALUE,
      M_END,
      M_ERROR
   } mode_type;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
          || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // parse state
   mode_type               mode_ff, mode_in;
   err_type                err_ff, err_in;
   logic [HELD_BITS-1:0]   held_ff, held_in;
   logic                   nonempty_ff, nonempty_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic                   cr_ff, cr_in;

   // per-word snapshot
   kind_type               p_kind_ff;
   logic [7:0]             p_byte_ff;
   err_type                p_err_ff;
   logic                   end2_ff;
   logic [HELD_BITS-1:0]   drain_ff;
   logic [HELD_BITS-1:0]   idx_ff, idx_in;
   logic [LINE_BITS-1:0]   snap_line_ff;
   logic [COLUMN_BITS-1:0] snap_col_ff, snap_col;

   // output register
   kind_type               o_kind_ff;
   logic [7:0]             o_byte_ff;
   err_type                o_err_ff;
   logic [LINE_BITS-1:0]   o_line_ff;
   logic [COLUMN_BITS-1:0] o_col_ff;
   logic                   o_last_ff;

   // step decode
   logic                   has_res, end2, wr_en, tok, fail, newline, is_nl;
   kind_type               p_kind, tok_kind;
   logic [7:0]             p_byte;
   err_type                p_err, fail_code;
   logic [HELD_BITS-1:0]   drain;
   logic [COLUMN_BITS-1:0] col_up;
   logic [ADDR_BITS-1:0]   raddr;
   logic [7:0]             rdata;

   always_comb begin
      mode_in     = mode_ff;
      err_in      = err_ff;
      held_in     = held_ff;
      nonempty_in = nonempty_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      cr_in       = cr_ff;
      has_res     = 1'b0;
      end2        = 1'b0;
      wr_en       = 1'b0;
      tok         = 1'b0;
      tok_kind    = K_NAME_CHAR;
      fail        = 1'b0;
      fail_code   = E_NONE;
      newline     = 1'b0;
      p_kind      = K_END;
      p_byte      = 8'd0;
      p_err       = E_NONE;
      drain       = '0;
      snap_col    = col_ff;
      col_up      = (col_ff == COL_MAX) ? col_ff : col_ff + 1'b1;
      is_nl       = req_text_byte == CH_CR || req_text_byte == CH_LF;

      if (mode_ff == M_END) begin
         has_res = 1'b1;
      end else if (mode_ff == M_ERROR) begin
         has_res = 1'b1;
         p_kind  = K_ERROR;
         p_err   = err_ff;
      end else if (req_at_end) begin
         if (mode_ff == M_SECTION || mode_ff == M_PARAM) begin
            fail      = 1'b1;
            fail_code = E_EARLY;
         end else begin
            has_res = 1'b1;
            mode_in = M_END;
            if (mode_ff == M_VALUE) begin
               p_kind  = K_VALUE_DONE;
               end2    = 1'b1;
               held_in = '0;
            end
         end
      end else if (cr_ff && req_text_byte == CH_LF) begin
         // second half of CRLF
         cr_in = 1'b0;
      end else begin
         cr_in    = req_text_byte == CH_CR;
         col_in   = col_up;
         snap_col = col_up;
         case (mode_ff)
            M_GEN: begin
               if (is_nl) begin
                  newline = 1'b1;
               end else if (req_text_byte == CH_SEMI) begin
                  mode_in = M_COMMENT;
               end else if (req_text_byte == CH_OPEN) begin
                  mode_in     = M_SECTION;
                  held_in     = '0;
                  nonempty_in = 1'b0;
               end else if (is_blank(req_text_byte)) begin
                  mode_in = M_GEN;
               end else if (is_alnum(req_text_byte)) begin
                  mode_in     = M_PARAM;
                  has_res     = 1'b1;
                  p_kind      = K_NAME_CHAR;
                  p_byte      = req_text_byte;
                  held_in     = '0;
                  nonempty_in = 1'b1;
               end else begin
                  fail      = 1'b1;
                  fail_code = E_SYMBOL;
               end
            end
            M_COMMENT: begin
               if (is_nl) begin
                  newline = 1'b1;
                  mode_in = M_GEN;
               end
            end
            M_SECTION: begin
               if (req_text_byte == CH_SEMI) begin
                  fail      = 1'b1;
                  fail_code = E_COMMENT;
               end else if (is_nl) begin
                  fail      = 1'b1;
                  fail_code = E_LINE;
               end else if (req_text_byte == CH_CLOSE) begin
                  if (nonempty_ff) begin
                     has_res = 1'b1;
                     p_kind  = K_SECTION_DONE;
                     held_in = '0;
                     mode_in = M_GEN;
                  end else begin
                     fail      = 1'b1;
                     fail_code = E_EMPTY;
                  end
               end else begin
                  tok      = 1'b1;
                  tok_kind = K_SECTION_CHAR;
               end
            end
            M_PARAM: begin
               if (req_text_byte == CH_SEMI) begin
                  fail      = 1'b1;
                  fail_code = E_COMMENT;
               end else if (is_nl) begin
                  fail      = 1'b1;
                  fail_code = E_LINE;
               end else if (req_text_byte == CH_EQ) begin
                  has_res     = 1'b1;
                  p_kind      = K_NAME_DONE;
                  held_in     = '0;
                  nonempty_in = 1'b0;
                  mode_in     = M_VALUE;
               end else begin
                  tok      = 1'b1;
                  tok_kind = K_NAME_CHAR;
               end
            end
            default: begin
               if (is_nl || req_text_byte == CH_SEMI) begin
                  has_res = 1'b1;
                  p_kind  = K_VALUE_DONE;
                  held_in = '0;
                  newline = is_nl;
                  mode_in = is_nl ? M_GEN : M_COMMENT;
               end else begin
                  tok      = 1'b1;
                  tok_kind = K_VALUE_CHAR;
               end
            end
         endcase

         if (tok) begin
            if (is_blank(req_text_byte)) begin
               if (nonempty_ff) begin
                  if (held_ff >= HELD_BITS'(PENDING_DEPTH)) begin
                     fail      = 1'b1;
                     fail_code = E_OVERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     held_in = held_ff + 1'b1;
                  end
               end
            end else begin
               // held blanks go out first, then this byte
               drain       = held_ff;
               has_res     = 1'b1;
               p_kind      = tok_kind;
               p_byte      = req_text_byte;
               held_in     = '0;
               nonempty_in = 1'b1;
            end
         end

         if (newline) begin
            line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
            col_in  = '0;
         end
      end

      if (fail) begin
         mode_in = M_ERROR;
         err_in  = fail_code;
         has_res = 1'b1;
         p_kind  = K_ERROR;
         p_byte  = 8'd0;
         p_err   = fail_code;
         end2    = 1'b0;
      end
   end

   assign status.step_has_res = has_res;
   assign status.step_drain   = drain != '0;
   assign status.step_end2    = end2;
   assign status.held_end2    = end2_ff;
   assign status.drain_last   = (idx_ff + 1'b1) == drain_ff;

   always_comb begin
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.out_sel == OSEL_DRAIN) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
      // read data lines up with idx_ff on the following cycle
      raddr = (idx_in < HELD_BITS'(PENDING_DEPTH)) ? idx_in[ADDR_BITS-1:0] : '0;
   end

   ist_ram #(
      .WIDTH (8),
      .DEPTH (PENDING_DEPTH)
   ) u_held (
      .clock (clock),
      .we    (cmd.accept && wr_en),
      .waddr (held_ff[ADDR_BITS-1:0]),
      .wdata (req_text_byte),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_GEN;
         err_ff      <= E_NONE;
         held_ff     <= '0;
         nonempty_ff <= 1'b0;
         line_ff     <= '0;
         col_ff      <= '0;
         cr_ff       <= 1'b0;
         idx_ff      <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.accept) begin
            mode_ff     <= mode_in;
            err_ff      <= err_in;
            held_ff     <= held_in;
            nonempty_ff <= nonempty_in;
            line_ff     <= line_in;
            col_ff      <= col_in;
            cr_ff       <= cr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         p_kind_ff    <= p_kind;
         p_byte_ff    <= p_byte;
         p_err_ff     <= p_err;
         end2_ff      <= end2;
         drain_ff     <= drain;
         snap_line_ff <= line_ff;
         snap_col_ff  <= snap_col;
      end
      case (cmd.out_sel)
         OSEL_DIRECT: begin
            o_kind_ff <= p_kind;
            o_byte_ff <= p_byte;
            o_err_ff  <= p_err;
            o_line_ff <= line_ff;
            o_col_ff  <= snap_col;
            o_last_ff <= cmd.out_last;
         end
         OSEL_DRAIN: begin
            o_kind_ff <= p_kind_ff;
            o_byte_ff <= rdata;
            o_err_ff  <= E_NONE;
            o_line_ff <= snap_line_ff;
            o_col_ff  <= snap_col_ff;
            o_last_ff <= cmd.out_last;
         end
         OSEL_HELD: begin
            o_kind_ff <= p_kind_ff;
            o_byte_ff <= p_byte_ff;
            o_err_ff  <= p_err_ff;
            o_line_ff <= snap_line_ff;
            o_col_ff  <= snap_col_ff;
            o_last_ff <= cmd.out_last;
         end
         OSEL_END: begin
            o_kind_ff <= K_END;
            o_byte_ff <= 8'd0;
            o_err_ff  <= E_NONE;
            o_line_ff <= snap_line_ff;
            o_col_ff  <= snap_col_ff;
            o_last_ff <= cmd.out_last;
         end
         default: begin
            o_kind_ff <= o_kind_ff;
         end
      endcase
   end

   assign rsp_kind          = o_kind_ff;
   assign rsp_out_byte      = o_byte_ff;
   assign rsp_error_code    = o_err_ff;
   assign rsp_line_number   = o_line_ff;
   assign rsp_column_number = o_col_ff;
   assign rsp_last_of_run   = o_last_ff;

endmodule

/* hw/rtl/ini_stream_tokenizer.sv */
// Top level of the INI stream tokeniser.
// Depends on ist_pkg, ist_ctrl and ist_datapath.
//
// Input channel (req_): one text byte per word, or an end marker with
// req_at_end high. Output channel (rsp_): tagged token words carrying kind,
// character, error code and line/column position; rsp_last_of_run marks the
// final word caused by one input word.
// Throughput: an input word that causes at most one output word is taken
// every cycle while the receiver keeps up. A byte that releases held
// trailing blanks keeps req_ready low while the blank buffer, which has a
// registered read port, is read out one entry per cycle while the receiver
// keeps up, and then while the byte goes out; the value done plus end pair
// at end of input goes out as two words. A word with no blanks ahead of it
// appears in the cycle after its input; held blanks leave via the drain state.
// Reset clears the parse state and counters; the block then expects the
// start of a line. The blank buffer needs no clearing.
// When the receiver stalls, the output word holds and req_ready stays low
// until the output register can be reloaded; nothing is dropped. After end
// or an error every further input word returns one end or error word.
module ini_stream_tokenizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_text_byte,
   input  logic                            req_at_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_kind,
   output logic [7:0]                      rsp_out_byte,
   output logic [2:0]                      rsp_error_code,
   output logic [ist_pkg::LINE_BITS-1:0]   rsp_line_number,
   output logic [ist_pkg::COLUMN_BITS-1:0] rsp_column_number,
   output logic                            rsp_last_of_run
);
   import ist_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   ist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ist_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_text_byte     (req_text_byte),
      .req_at_end        (req_at_end),
      .cmd               (cmd),
      .status            (status),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
